/* hdl/wpc_pkg.sv */
// wpc_pkg: shared types, fixed-point gains, limits and helpers for the waypoint controller
// used by wpc_cordic, wpc_div and waypoint_attitude_throttle_controller
`default_nettype none
package wpc_pkg;

    localparam int FRAC_BITS = 16;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TRIG,
        S_MUL,
        S_ACC,
        S_FIN
    } state_t;

    typedef enum logic [4:0] {
        ST_SQX, ST_SQY, ST_SQZ,
        ST_H0, ST_H1, ST_K0, ST_K1,
        ST_BX0, ST_BX1, ST_T0, ST_T1, ST_BY0, ST_BY1,
        ST_DESV, ST_DR, ST_DESU, ST_DP, ST_DY,
        ST_IZ, ST_PZ, ST_IIZ, ST_DZ
    } step_t;

    typedef enum logic [1:0] {
        REG_GOAL_X       = 2'd0,
        REG_GOAL_Y       = 2'd1,
        REG_GOAL_Z       = 2'd2,
        REG_GOAL_HEADING = 2'd3
    } reg_idx_t;

    // gains, Q16.16
    localparam logic signed [20:0] K_XY  = 21'sd58982;
    localparam logic signed [20:0] K_V   = 21'sd5898;
    localparam logic signed [20:0] K_IZ  = 21'sd52;
    localparam logic signed [20:0] K_PZ  = 21'sd1966;
    localparam logic signed [20:0] K_DZ  = 21'sd2621;
    localparam logic signed [20:0] K_YAW = 21'sd393216;

    // limits
    localparam logic signed [59:0] HOVER    = 60'sd38666;
    localparam logic signed [59:0] TILT_MAX = 60'sd22282;
    localparam logic signed [59:0] YAW_MAX  = 60'sd288358;
    localparam logic signed [59:0] VEL_MAX  = 60'sd196608;
    localparam logic signed [59:0] ONE_Q    = 60'sd65536;
    localparam logic signed [59:0] INT_MAX  = 60'sd140737488355327;
    localparam logic signed [59:0] INT_MIN  = -60'sd140737488355328;
    localparam logic signed [59:0] W_MAX    = 60'sd2147483647;
    localparam logic signed [59:0] W_MIN    = -60'sd2147483648;
    localparam logic signed [57:0] GOAL_SQ  = 58'sd17179869184;
    localparam logic signed [31:0] GOAL_DIST = 32'sd131072;

    // cordic angles, Q30
    localparam logic signed [34:0] PI30     = 35'sd3373259426;
    localparam logic signed [34:0] HALFPI30 = 35'sd1686629713;
    localparam logic signed [34:0] TWOPI30  = 35'sd6746518852;
    localparam logic signed [33:0] GAIN30   = 34'sd652032874;

    function automatic logic [29:0] atan_q30(input logic [4:0] idx);
        logic [29:0] r;
        case (idx)
            5'd0:  r = 30'd843314857;
            5'd1:  r = 30'd497837829;
            5'd2:  r = 30'd263043836;
            5'd3:  r = 30'd133525158;
            5'd4:  r = 30'd67021686;
            5'd5:  r = 30'd33543515;
            5'd6:  r = 30'd16775850;
            5'd7:  r = 30'd8388437;
            5'd8:  r = 30'd4194282;
            5'd9:  r = 30'd2097149;
            5'd10: r = 30'd1048575;
            5'd11: r = 30'd524287;
            5'd12: r = 30'd262143;
            5'd13: r = 30'd131071;
            5'd14: r = 30'd65535;
            5'd15: r = 30'd32767;
            5'd16: r = 30'd16383;
            5'd17: r = 30'd8191;
            5'd18: r = 30'd4095;
            5'd19: r = 30'd2047;
            5'd20: r = 30'd1023;
            5'd21: r = 30'd511;
            5'd22: r = 30'd255;
            5'd23: r = 30'd127;
            5'd24: r = 30'd63;
            5'd25: r = 30'd31;
            5'd26: r = 30'd15;
            5'd27: r = 30'd8;
            5'd28: r = 30'd4;
            5'd29: r = 30'd2;
            default: r = 30'd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [59:0] sat(input logic signed [59:0] x,
                                               input logic signed [59:0] lo,
                                               input logic signed [59:0] hi);
        logic signed [59:0] r;
        if (x < lo) begin
            r = lo;
        end else if (x > hi) begin
            r = hi;
        end else begin
            r = x;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* hdl/wpc_cordic.sv */
// wpc_cordic: iterative sine/cosine, one rotation step per cycle, Q30 inside, Q2.16 out
// depends on wpc_pkg (angle constants, arctangent table)
`default_nettype none
module wpc_cordic (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [18:0] angle,
    output logic               done,
    output logic signed [17:0] sin_q,
    output logic signed [17:0] cos_q
);

    logic               busy_reg;
    logic               done_reg;
    logic [4:0]         it_reg;
    logic               neg_reg;
    logic signed [33:0] x_reg;
    logic signed [33:0] y_reg;
    logic signed [34:0] z_reg;
    logic signed [17:0] sin_reg;
    logic signed [17:0] cos_reg;

    logic signed [34:0] z_a;
    logic signed [34:0] z_b;
    logic               neg_b;
    logic signed [33:0] x_sh;
    logic signed [33:0] y_sh;
    logic signed [34:0] at;
    logic signed [33:0] x_rnd;
    logic signed [33:0] y_rnd;

    // fold into -pi/2..pi/2
    always_comb begin
        z_a = 35'(angle) <<< 14;
        if (z_a > wpc_pkg::PI30) begin
            z_a = z_a - wpc_pkg::TWOPI30;
        end else if (z_a < -wpc_pkg::PI30) begin
            z_a = z_a + wpc_pkg::TWOPI30;
        end
        neg_b = 1'b0;
        z_b   = z_a;
        if (z_a > wpc_pkg::HALFPI30) begin
            z_b   = z_a - wpc_pkg::PI30;
            neg_b = 1'b1;
        end else if (z_a < -wpc_pkg::HALFPI30) begin
            z_b   = z_a + wpc_pkg::PI30;
            neg_b = 1'b1;
        end
    end

    assign x_sh  = x_reg >>> it_reg;
    assign y_sh  = y_reg >>> it_reg;
    assign at    = $signed({5'd0, wpc_pkg::atan_q30(it_reg)});
    assign x_rnd = (x_reg + 34'sd8192) >>> 14;
    assign y_rnd = (y_reg + 34'sd8192) >>> 14;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            it_reg   <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                it_reg   <= '0;
            end else if (busy_reg) begin
                if (it_reg == 5'd30) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    it_reg <= it_reg + 5'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg   <= wpc_pkg::GAIN30;
            y_reg   <= '0;
            z_reg   <= z_b;
            neg_reg <= neg_b;
        end else if (busy_reg) begin
            if (it_reg == 5'd30) begin
                cos_reg <= neg_reg ? 18'(-x_rnd) : 18'(x_rnd);
                sin_reg <= neg_reg ? 18'(-y_rnd) : 18'(y_rnd);
            end else if (!z_reg[34]) begin
                x_reg <= x_reg - y_sh;
                y_reg <= y_reg + x_sh;
                z_reg <= z_reg - at;
            end else begin
                x_reg <= x_reg + y_sh;
                y_reg <= y_reg - x_sh;
                z_reg <= z_reg + at;
            end
        end
    end

    assign done  = done_reg;
    assign sin_q = sin_reg;
    assign cos_q = cos_reg;

    cordic_iter_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> it_reg <= 5'd30)
        else $error("cordic step count out of range");
    cordic_done_once: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg)
        else $error("cordic done held");
    cordic_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg))
        else $error("cordic done without run");

endmodule
`default_nettype wire

/* hdl/wpc_div.sv */
// wpc_div: restoring divider, one quotient bit per cycle, for the altitude error rate
// depends on wpc_pkg (word limits)
`default_nettype none
module wpc_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [32:0] diff,
    input  logic [19:0]        divisor,
    output logic signed [31:0] quot,
    output logic               busy
);

    logic               busy_reg;
    logic [5:0]         cnt_reg;
    logic [48:0]        num_reg;
    logic [19:0]        rem_reg;
    logic [48:0]        q_reg;
    logic               neg_reg;
    logic [19:0]        dv_reg;
    logic signed [31:0] quot_reg;

    logic [32:0] mag;
    logic [20:0] trial;
    logic        take;
    logic [48:0] q_new;

    assign mag   = diff[32] ? 33'(-diff) : 33'(diff);
    assign trial = {rem_reg, num_reg[48]};
    assign take  = trial >= {1'b0, dv_reg};
    assign q_new = {q_reg[47:0], take};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            if (start) begin
                busy_reg <= (divisor != 20'd0);
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd48) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg  <= {mag, 16'd0};
            rem_reg  <= '0;
            q_reg    <= '0;
            neg_reg  <= diff[32];
            dv_reg   <= divisor;
            quot_reg <= '0;
        end else if (busy_reg) begin
            num_reg <= {num_reg[47:0], 1'b0};
            q_reg   <= q_new;
            rem_reg <= take ? 20'(trial - {1'b0, dv_reg}) : trial[19:0];
            if (cnt_reg == 6'd48) begin
                if (neg_reg) begin
                    quot_reg <= (q_new > 49'd2147483648) ? 32'(wpc_pkg::W_MIN)
                                                         : 32'(-q_new);
                end else begin
                    quot_reg <= (q_new > 49'd2147483647) ? 32'(wpc_pkg::W_MAX)
                                                         : 32'(q_new);
                end
            end
        end
    end

    assign quot = quot_reg;
    assign busy = busy_reg;

    div_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> rem_reg < dv_reg)
        else $error("divider remainder not below divisor");
    div_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> cnt_reg <= 6'd48)
        else $error("divider step count out of range");
    div_zero_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start && divisor == 20'd0 |=> !busy_reg)
        else $error("divider ran on zero divisor");

endmodule
`default_nettype wire

/* hdl/waypoint_attitude_throttle_controller.sv */
// waypoint_attitude_throttle_controller: cascaded position/velocity loops, yaw-rate law and
// altitude pid; one shared multiplier under a step sequencer, wpc_cordic and wpc_div
// a control request runs 3 cordic passes (roll, pitch, yaw) one after another, with the
// divider started beside the first, then 22 multiply steps, then the result load
// a new request is taken only in idle, once the result is loaded; loading waits on m_ready
// clear requests finish in the accept cycle; reset (synchronous) zeroes goals and pid memory
`default_nettype none
module waypoint_attitude_throttle_controller (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_operation,
    input  logic signed [31:0] s_pos_x,
    input  logic signed [31:0] s_pos_y,
    input  logic signed [31:0] s_pos_z,
    input  logic signed [18:0] s_att_roll,
    input  logic signed [18:0] s_att_pitch,
    input  logic signed [18:0] s_att_yaw,
    input  logic signed [31:0] s_vel_forward,
    input  logic signed [31:0] s_vel_lateral,
    input  logic [19:0]        s_time_step,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_roll_cmd,
    output logic signed [15:0] m_pitch_cmd,
    output logic signed [19:0] m_yaw_rate_cmd,
    output logic [16:0]        m_throttle_cmd,
    output logic               m_goal_reached
);

    wpc_pkg::state_t    state_reg, state_next;
    wpc_pkg::step_t     step_reg;
    logic [1:0]         idx_reg;
    logic               trig_busy_reg;

    logic signed [31:0] goal_x_reg, goal_y_reg, goal_z_reg;
    logic signed [18:0] goal_hd_reg;
    logic               reached_reg;
    logic signed [47:0] ai_reg;
    logic signed [31:0] last_reg;

    logic signed [31:0] ex_reg, ey_reg, ez_reg, u_reg, v_reg;
    logic signed [18:0] roll_reg, pitch_reg, yaw_reg;
    logic [19:0]        dt_reg;
    logic signed [17:0] sr_reg, cr_reg, sp_reg, cp_reg, sy_reg, cy_reg;
    logic signed [68:0] prod_reg;
    logic signed [57:0] acc_reg;
    logic signed [39:0] h_reg, k_reg, bx_reg, t_reg, by_reg;
    logic signed [19:0] vel_reg;
    logic signed [15:0] dr_reg, dp_reg;
    logic signed [19:0] dy_reg;
    logic signed [47:0] iz_reg;
    logic signed [57:0] desth_reg;

    logic               m_valid_reg;
    logic signed [15:0] m_roll_reg, m_pitch_reg;
    logic signed [19:0] m_yaw_reg;
    logic [16:0]        m_th_reg;
    logic               m_reached_reg;

    logic               accept;
    logic               cfg_wr;
    logic               cordic_start;
    logic               cordic_done;
    logic signed [18:0] cordic_angle;
    logic signed [17:0] cordic_sin, cordic_cos;
    logic               div_start;
    logic               div_busy;
    logic signed [31:0] de;
    logic               out_load;

    logic signed [47:0] mul_a;
    logic signed [20:0] mul_b;
    logic signed [68:0] prod_sum;
    logic signed [57:0] rnd_v;
    logic signed [57:0] raw_v;
    logic               in_range;
    logic signed [59:0] th_v;
    logic signed [59:0] ai_v;

    logic signed [32:0] dx, dy_e, dz;

    assign accept = s_valid && s_ready;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_comb begin
        case (paddr[3:2])
            wpc_pkg::REG_GOAL_X:       prdata = goal_x_reg;
            wpc_pkg::REG_GOAL_Y:       prdata = goal_y_reg;
            wpc_pkg::REG_GOAL_Z:       prdata = goal_z_reg;
            wpc_pkg::REG_GOAL_HEADING: prdata = 32'(goal_hd_reg);
            default:                   prdata = '0;
        endcase
    end

    // position error, saturated to a 32-bit word when registered
    assign dx   = 33'(goal_x_reg) - 33'(s_pos_x);
    assign dy_e = 33'(goal_y_reg) - 33'(s_pos_y);
    assign dz   = 33'(goal_z_reg) - 33'(s_pos_z);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            wpc_pkg::S_IDLE: begin
                if (accept && !s_operation) begin
                    state_next = wpc_pkg::S_TRIG;
                end
            end
            wpc_pkg::S_TRIG: begin
                if (cordic_done && idx_reg == 2'd2) begin
                    state_next = wpc_pkg::S_MUL;
                end
            end
            wpc_pkg::S_MUL: state_next = wpc_pkg::S_ACC;
            wpc_pkg::S_ACC: begin
                state_next = (step_reg == wpc_pkg::ST_DZ) ? wpc_pkg::S_FIN : wpc_pkg::S_MUL;
            end
            wpc_pkg::S_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = wpc_pkg::S_IDLE;
                end
            end
            default: state_next = wpc_pkg::S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_ready      = (state_reg == wpc_pkg::S_IDLE);
        cordic_start = (state_reg == wpc_pkg::S_TRIG) && !trig_busy_reg;
        div_start    = (state_reg == wpc_pkg::S_TRIG) && !trig_busy_reg && idx_reg == 2'd0;
        out_load     = (state_reg == wpc_pkg::S_FIN) && (!m_valid_reg || m_ready);
    end

    always_comb begin
        case (idx_reg)
            2'd0:    cordic_angle = roll_reg;
            2'd1:    cordic_angle = pitch_reg;
            default: cordic_angle = yaw_reg;
        endcase
    end

    wpc_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cordic_start),
        .angle   (cordic_angle),
        .done    (cordic_done),
        .sin_q   (cordic_sin),
        .cos_q   (cordic_cos)
    );

    wpc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .diff    (33'(ez_reg) - 33'(last_reg)),
        .divisor (dt_reg),
        .quot    (de),
        .busy    (div_busy)
    );

    // shared multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (step_reg)
            wpc_pkg::ST_SQX:  begin mul_a = 48'(ex_reg); mul_b = ex_reg[20:0]; end
            wpc_pkg::ST_SQY:  begin mul_a = 48'(ey_reg); mul_b = ey_reg[20:0]; end
            wpc_pkg::ST_SQZ:  begin mul_a = 48'(ez_reg); mul_b = ez_reg[20:0]; end
            wpc_pkg::ST_H0:   begin mul_a = 48'(ex_reg); mul_b = 21'(cy_reg); end
            wpc_pkg::ST_H1:   begin mul_a = 48'(ey_reg); mul_b = 21'(sy_reg); end
            wpc_pkg::ST_K0:   begin mul_a = 48'(ey_reg); mul_b = 21'(cy_reg); end
            wpc_pkg::ST_K1:   begin mul_a = 48'(ex_reg); mul_b = 21'(sy_reg); end
            wpc_pkg::ST_BX0:  begin mul_a = 48'(h_reg);  mul_b = 21'(cp_reg); end
            wpc_pkg::ST_BX1:  begin mul_a = 48'(ez_reg); mul_b = 21'(sp_reg); end
            wpc_pkg::ST_T0:   begin mul_a = 48'(h_reg);  mul_b = 21'(sp_reg); end
            wpc_pkg::ST_T1:   begin mul_a = 48'(ez_reg); mul_b = 21'(cp_reg); end
            wpc_pkg::ST_BY0:  begin mul_a = 48'(t_reg);  mul_b = 21'(sr_reg); end
            wpc_pkg::ST_BY1:  begin mul_a = 48'(k_reg);  mul_b = 21'(cr_reg); end
            wpc_pkg::ST_DESV: begin mul_a = 48'(by_reg); mul_b = wpc_pkg::K_XY; end
            wpc_pkg::ST_DR: begin
                mul_a = 48'(34'(vel_reg) - 34'(v_reg));
                mul_b = wpc_pkg::K_V;
            end
            wpc_pkg::ST_DESU: begin mul_a = 48'(bx_reg); mul_b = wpc_pkg::K_XY; end
            wpc_pkg::ST_DP: begin
                mul_a = 48'(34'(vel_reg) - 34'(u_reg));
                mul_b = wpc_pkg::K_V;
            end
            wpc_pkg::ST_DY: begin
                mul_a = 48'(21'(goal_hd_reg) - 21'(yaw_reg));
                mul_b = wpc_pkg::K_YAW;
            end
            wpc_pkg::ST_IZ:   begin mul_a = 48'(ez_reg); mul_b = $signed({1'b0, dt_reg}); end
            wpc_pkg::ST_PZ:   begin mul_a = 48'(ez_reg); mul_b = wpc_pkg::K_PZ; end
            wpc_pkg::ST_IIZ:  begin mul_a = iz_reg;      mul_b = wpc_pkg::K_IZ; end
            wpc_pkg::ST_DZ:   begin mul_a = 48'(de);     mul_b = wpc_pkg::K_DZ; end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_sum = prod_reg + 69'sd32768;
    assign rnd_v    = 58'(prod_sum >>> wpc_pkg::FRAC_BITS);
    assign raw_v    = 58'(prod_reg);
    assign in_range = ex_reg > -wpc_pkg::GOAL_DIST && ex_reg < wpc_pkg::GOAL_DIST
                   && ey_reg > -wpc_pkg::GOAL_DIST && ey_reg < wpc_pkg::GOAL_DIST
                   && ez_reg > -wpc_pkg::GOAL_DIST && ez_reg < wpc_pkg::GOAL_DIST;
    assign th_v     = wpc_pkg::sat(60'(desth_reg), 60'sd0, wpc_pkg::ONE_Q);
    assign ai_v     = wpc_pkg::sat(60'(iz_reg) - 60'sd2 * (60'(desth_reg) - th_v),
                                   wpc_pkg::INT_MIN, wpc_pkg::INT_MAX);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= wpc_pkg::S_IDLE;
            step_reg      <= wpc_pkg::ST_SQX;
            idx_reg       <= '0;
            trig_busy_reg <= 1'b0;
            goal_x_reg    <= '0;
            goal_y_reg    <= '0;
            goal_z_reg    <= '0;
            goal_hd_reg   <= '0;
            reached_reg   <= 1'b0;
            ai_reg        <= '0;
            last_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr) begin
                reached_reg <= 1'b0;
                case (paddr[3:2])
                    wpc_pkg::REG_GOAL_X:       goal_x_reg  <= pwdata;
                    wpc_pkg::REG_GOAL_Y:       goal_y_reg  <= pwdata;
                    wpc_pkg::REG_GOAL_Z:       goal_z_reg  <= pwdata;
                    wpc_pkg::REG_GOAL_HEADING: goal_hd_reg <= pwdata[18:0];
                    default: reached_reg <= reached_reg;
                endcase
            end
            if (accept && s_operation) begin
                ai_reg   <= '0;
                last_reg <= '0;
            end
            if (accept && !s_operation) begin
                idx_reg       <= '0;
                trig_busy_reg <= 1'b0;
                step_reg      <= wpc_pkg::ST_SQX;
            end
            if (cordic_start) begin
                trig_busy_reg <= 1'b1;
            end else if (cordic_done) begin
                trig_busy_reg <= 1'b0;
                idx_reg       <= idx_reg + 2'd1;
            end
            if (state_reg == wpc_pkg::S_ACC) begin
                if (step_reg == wpc_pkg::ST_SQZ && in_range
                    && (acc_reg + raw_v) < wpc_pkg::GOAL_SQ) begin
                    reached_reg <= 1'b1;
                end
                if (step_reg != wpc_pkg::ST_DZ) begin
                    step_reg <= wpc_pkg::step_t'(step_reg + 5'd1);
                end
            end
            if (out_load) begin
                ai_reg      <= 48'(ai_v);
                last_reg    <= ez_reg;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (accept) begin
            ex_reg    <= 32'(wpc_pkg::sat(60'(dx), wpc_pkg::W_MIN, wpc_pkg::W_MAX));
            ey_reg    <= 32'(wpc_pkg::sat(60'(dy_e), wpc_pkg::W_MIN, wpc_pkg::W_MAX));
            ez_reg    <= 32'(wpc_pkg::sat(60'(dz), wpc_pkg::W_MIN, wpc_pkg::W_MAX));
            roll_reg  <= s_att_roll;
            pitch_reg <= s_att_pitch;
            yaw_reg   <= s_att_yaw;
            u_reg     <= s_vel_forward;
            v_reg     <= s_vel_lateral;
            dt_reg    <= s_time_step;
        end
        if (cordic_done) begin
            case (idx_reg)
                2'd0: begin sr_reg <= cordic_sin; cr_reg <= cordic_cos; end
                2'd1: begin sp_reg <= cordic_sin; cp_reg <= cordic_cos; end
                default: begin sy_reg <= cordic_sin; cy_reg <= cordic_cos; end
            endcase
        end
        if (state_reg == wpc_pkg::S_MUL) begin
            prod_reg <= mul_a * mul_b;
        end
        if (state_reg == wpc_pkg::S_ACC) begin
            case (step_reg)
                wpc_pkg::ST_SQX:  acc_reg <= raw_v;
                wpc_pkg::ST_SQY:  acc_reg <= acc_reg + raw_v;
                wpc_pkg::ST_SQZ:  acc_reg <= acc_reg + raw_v;
                wpc_pkg::ST_H0:   acc_reg <= rnd_v;
                wpc_pkg::ST_H1:   h_reg   <= 40'(acc_reg + rnd_v);
                wpc_pkg::ST_K0:   acc_reg <= rnd_v;
                wpc_pkg::ST_K1:   k_reg   <= 40'(acc_reg - rnd_v);
                wpc_pkg::ST_BX0:  acc_reg <= rnd_v;
                wpc_pkg::ST_BX1:  bx_reg  <= 40'(acc_reg - rnd_v);
                wpc_pkg::ST_T0:   acc_reg <= rnd_v;
                wpc_pkg::ST_T1:   t_reg   <= 40'(acc_reg + rnd_v);
                wpc_pkg::ST_BY0:  acc_reg <= rnd_v;
                wpc_pkg::ST_BY1:  by_reg  <= 40'(acc_reg + rnd_v);
                wpc_pkg::ST_DESV, wpc_pkg::ST_DESU: begin
                    vel_reg <= 20'(wpc_pkg::sat(60'(rnd_v), -wpc_pkg::VEL_MAX,
                                                wpc_pkg::VEL_MAX));
                end
                wpc_pkg::ST_DR: begin
                    dr_reg <= 16'(wpc_pkg::sat(-60'(rnd_v), -wpc_pkg::TILT_MAX,
                                               wpc_pkg::TILT_MAX));
                end
                wpc_pkg::ST_DP: begin
                    dp_reg <= 16'(wpc_pkg::sat(60'(rnd_v), -wpc_pkg::TILT_MAX,
                                               wpc_pkg::TILT_MAX));
                end
                wpc_pkg::ST_DY: begin
                    dy_reg <= 20'(wpc_pkg::sat(60'(rnd_v), -wpc_pkg::YAW_MAX,
                                               wpc_pkg::YAW_MAX));
                end
                wpc_pkg::ST_IZ: begin
                    iz_reg <= 48'(wpc_pkg::sat(60'(ai_reg) + 60'(rnd_v), wpc_pkg::INT_MIN,
                                               wpc_pkg::INT_MAX));
                end
                wpc_pkg::ST_PZ:   acc_reg <= rnd_v;
                wpc_pkg::ST_IIZ:  acc_reg <= acc_reg + rnd_v;
                wpc_pkg::ST_DZ:   desth_reg <= acc_reg + rnd_v + 58'(wpc_pkg::HOVER);
                default:          acc_reg <= acc_reg;
            endcase
        end
        if (out_load) begin
            m_roll_reg    <= dr_reg;
            m_pitch_reg   <= dp_reg;
            m_yaw_reg     <= dy_reg;
            m_th_reg      <= 17'(th_v);
            m_reached_reg <= reached_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_roll_cmd     = m_roll_reg;
    assign m_pitch_cmd    = m_pitch_reg;
    assign m_yaw_rate_cmd = m_yaw_reg;
    assign m_throttle_cmd = m_th_reg;
    assign m_goal_reached = m_reached_reg;

    top_div_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == wpc_pkg::S_ACC && step_reg == wpc_pkg::ST_DZ |-> !div_busy)
        else $error("rate term used before divider finished");
    top_trig_only: assert property (@(posedge aclk) disable iff (!aresetn)
        cordic_done |-> state_reg == wpc_pkg::S_TRIG)
        else $error("cordic result outside trig phase");
    top_cfg_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr && paddr[3:2] == wpc_pkg::REG_GOAL_X |=> !reached_reg)
        else $error("setpoint write left reached flag set");
    top_th_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_th_reg <= 17'd65536)
        else $error("throttle out of range");

endmodule
`default_nettype wire

/* dv/testbench.sv */
// testbench for waypoint_attitude_throttle_controller: directed and random requests against
// a cycle-free predictor of the roll, pitch, yaw-rate and altitude pid laws
// depends on hdl/wpc_pkg.sv (register indexes, arctangent table) and the controller rtl
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint Q_ONE      = 65536;
    localparam longint G_XY       = 58982;
    localparam longint G_V        = 5898;
    localparam longint G_IZ       = 52;
    localparam longint G_PZ       = 1966;
    localparam longint G_DZ       = 2621;
    localparam longint G_YAW      = 393216;
    localparam longint HOVER_Q    = 38666;
    localparam longint TILT_Q     = 22282;
    localparam longint YAWRATE_Q  = 288358;
    localparam longint SPEED_Q    = 196608;
    localparam longint REACH_Q    = 131072;
    localparam longint WORD_HI    = 64'sd2147483647;
    localparam longint WORD_LO    = -64'sd2147483648;
    localparam longint ACC_HI     = 64'sd140737488355327;
    localparam longint ACC_LO     = -64'sd140737488355328;
    localparam longint PI_Q30     = 64'sd3373259426;
    localparam longint HALFPI_Q30 = 64'sd1686629713;
    localparam longint TWOPI_Q30  = 64'sd6746518852;
    localparam longint GAIN_Q30   = 64'sd652032874;
    localparam int     ANG_MAX    = 205888;
    localparam bit     OP_UPDATE  = 1'b0;
    localparam bit     OP_CLEAR   = 1'b1;
    localparam int     SETTLE     = 400;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct {
        bit                 op;
        logic signed [31:0] px, py, pz;
        logic signed [18:0] roll, pitch, yaw;
        logic signed [31:0] vu, vv;
        logic [19:0]        dt;
    } sample_t;

    typedef struct {
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [19:0] yaw_rate;
        logic [16:0]        throttle;
        logic               reached;
    } command_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_operation = 1'b0;
    logic signed [31:0] s_pos_x = '0, s_pos_y = '0, s_pos_z = '0;
    logic signed [18:0] s_att_roll = '0, s_att_pitch = '0, s_att_yaw = '0;
    logic signed [31:0] s_vel_forward = '0, s_vel_lateral = '0;
    logic [19:0] s_time_step = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [15:0] m_roll_cmd;
    logic signed [15:0] m_pitch_cmd;
    logic signed [19:0] m_yaw_rate_cmd;
    logic [16:0] m_throttle_cmd;
    logic m_goal_reached;

    // predictor state
    longint goal_x_q, goal_y_q, goal_z_q, goal_hdg_q;
    longint alt_integ, alt_last_err;
    bit reached_q;

    command_t pending_cmds[$];
    int errors = 0;
    int commands_seen = 0;
    int clears_sent = 0;
    int requests_sent = 0;
    longint cycles = 0;
    bit calm = 1'b0;

    waypoint_attitude_throttle_controller u_dut (.*);

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d commands outstanding",
                     cycles, pending_cmds.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic longint clip(longint x, longint lo, longint hi);
        return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    // rounded fixed-point product, ties upward
    function automatic longint qmul(longint a, longint b);
        longint hi, lo;
        hi = a >>> 16;
        lo = a - (hi <<< 16);
        return hi * b + ((lo * b + 32768) >>> 16);
    endfunction

    task automatic sin_cos(input longint ang, output longint s, output longint c);
        longint z, x, y, t;
        bit neg;
        z = (ang * 16384) % TWOPI_Q30;
        x = GAIN_Q30;
        y = 0;
        neg = 1'b0;
        if (z > PI_Q30) z -= TWOPI_Q30;
        else if (z < -PI_Q30) z += TWOPI_Q30;
        if (z > HALFPI_Q30) begin
            z -= PI_Q30;
            neg = 1'b1;
        end else if (z < -HALFPI_Q30) begin
            z += PI_Q30;
            neg = 1'b1;
        end
        for (int i = 0; i < 30; i++) begin
            if (z >= 0) begin
                t = x - (y >>> i);
                y = y + (x >>> i);
                z -= longint'(wpc_pkg::atan_q30(5'(i)));
            end else begin
                t = x + (y >>> i);
                y = y - (x >>> i);
                z += longint'(wpc_pkg::atan_q30(5'(i)));
            end
            x = t;
        end
        x = (x + 8192) >>> 14;
        y = (y + 8192) >>> 14;
        c = neg ? -x : x;
        s = neg ? -y : y;
    endtask

    task automatic predict_commands(input sample_t it);
        longint ex, ey, ez, sr, cr, sp, cp, sy, cy, h, k, bx, by;
        longint desv, desu, dr, dp, dy, iz, de, desth, th, dtv, diff, qi, r;
        command_t c;
        if (it.op == OP_CLEAR) begin
            alt_integ = 0;
            alt_last_err = 0;
            return;
        end
        ex = clip(goal_x_q - longint'(it.px), WORD_LO, WORD_HI);
        ey = clip(goal_y_q - longint'(it.py), WORD_LO, WORD_HI);
        ez = clip(goal_z_q - longint'(it.pz), WORD_LO, WORD_HI);
        dtv = longint'(it.dt);
        if (ex > -REACH_Q && ex < REACH_Q && ey > -REACH_Q && ey < REACH_Q &&
            ez > -REACH_Q && ez < REACH_Q && ex * ex + ey * ey + ez * ez < REACH_Q * REACH_Q)
            reached_q = 1'b1;
        sin_cos(longint'(it.roll), sr, cr);
        sin_cos(longint'(it.pitch), sp, cp);
        sin_cos(longint'(it.yaw), sy, cy);
        h = qmul(ex, cy) + qmul(ey, sy);
        k = qmul(ey, cy) - qmul(ex, sy);
        bx = qmul(h, cp) - qmul(ez, sp);
        by = qmul(qmul(h, sp) + qmul(ez, cp), sr) + qmul(k, cr);
        desv = clip(qmul(by, G_XY), -SPEED_Q, SPEED_Q);
        dr = clip(-qmul(desv - longint'(it.vv), G_V), -TILT_Q, TILT_Q);
        desu = clip(qmul(bx, G_XY), -SPEED_Q, SPEED_Q);
        dp = clip(qmul(desu - longint'(it.vu), G_V), -TILT_Q, TILT_Q);
        dy = clip(qmul(goal_hdg_q - longint'(it.yaw), G_YAW), -YAWRATE_Q, YAWRATE_Q);
        iz = clip(alt_integ + qmul(ez, dtv), ACC_LO, ACC_HI);
        de = 0;
        if (dtv > 0) begin
            diff = ez - alt_last_err;
            qi = clip(diff / dtv, -Q_ONE, Q_ONE);
            r = diff % dtv;
            de = clip(qi * Q_ONE + (r * Q_ONE) / dtv, WORD_LO, WORD_HI);
        end
        desth = HOVER_Q + qmul(ez, G_PZ) + qmul(iz, G_IZ) + qmul(de, G_DZ);
        th = clip(desth, 0, Q_ONE);
        alt_last_err = ez;
        alt_integ = clip(iz - 2 * (desth - th), ACC_LO, ACC_HI);
        c.roll = 16'(dr);
        c.pitch = 16'(dp);
        c.yaw_rate = 20'(dy);
        c.throttle = 17'(th);
        c.reached = reached_q;
        pending_cmds.push_back(c);
    endtask

    // result side
    always @(posedge aclk) begin
        command_t want;
        if (aresetn && m_valid && m_ready) begin
            commands_seen++;
            if (pending_cmds.size() == 0) begin
                $error("command with no request outstanding");
                errors++;
            end else begin
                want = pending_cmds.pop_front();
                if (m_roll_cmd !== want.roll) begin
                    $error("roll_cmd expected %0d got %0d", want.roll, m_roll_cmd);
                    errors++;
                end
                if (m_pitch_cmd !== want.pitch) begin
                    $error("pitch_cmd expected %0d got %0d", want.pitch, m_pitch_cmd);
                    errors++;
                end
                if (m_yaw_rate_cmd !== want.yaw_rate) begin
                    $error("yaw_rate_cmd expected %0d got %0d", want.yaw_rate, m_yaw_rate_cmd);
                    errors++;
                end
                if (m_throttle_cmd !== want.throttle) begin
                    $error("throttle_cmd expected %0d got %0d", want.throttle, m_throttle_cmd);
                    errors++;
                end
                if (m_goal_reached !== want.reached) begin
                    $error("goal_reached expected %0d got %0d", want.reached, m_goal_reached);
                    errors++;
                end
            end
        end
    end

    // receiver back-pressure
    initial begin
        int w;
        @(posedge aresetn);
        forever begin
            w = calm ? 0 : $urandom_range(0, 11);
            if (w > 0) begin
                m_ready <= 1'b0;
                repeat (w) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    task automatic send_request(input sample_t it);
        int w;
        w = calm ? 0 : $urandom_range(0, 11);
        if (w > 0) begin
            s_valid <= 1'b0;
            repeat (w) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_operation <= it.op;
        s_pos_x <= it.px;
        s_pos_y <= it.py;
        s_pos_z <= it.pz;
        s_att_roll <= it.roll;
        s_att_pitch <= it.pitch;
        s_att_yaw <= it.yaw;
        s_vel_forward <= it.vu;
        s_vel_lateral <= it.vv;
        s_time_step <= it.dt;
        do @(posedge aclk); while (!s_ready);
        predict_commands(it);
        if (it.op == OP_CLEAR) clears_sent++;
        else requests_sent++;
    endtask

    task automatic drain_and_settle();
        s_valid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_goal(input wpc_pkg::reg_idx_t idx, input longint value);
        drain_and_settle();
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 4'(idx) << 2;
        pwdata <= 32'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
        case (idx)
            wpc_pkg::REG_GOAL_X: goal_x_q = longint'(signed'(32'(value)));
            wpc_pkg::REG_GOAL_Y: goal_y_q = longint'(signed'(32'(value)));
            wpc_pkg::REG_GOAL_Z: goal_z_q = longint'(signed'(32'(value)));
            wpc_pkg::REG_GOAL_HEADING: goal_hdg_q = longint'(signed'(19'(value)));
            default: ;
        endcase
        reached_q = 1'b0;
    endtask

    function automatic sample_t make_sample(bit op, longint x, longint y, longint z,
                                            int r, int p, int yw, longint u, longint v,
                                            int dt);
        sample_t s;
        s.op = op;
        s.px = 32'(x);
        s.py = 32'(y);
        s.pz = 32'(z);
        s.roll = 19'(r);
        s.pitch = 19'(p);
        s.yaw = 19'(yw);
        s.vu = 32'(u);
        s.vv = 32'(v);
        s.dt = 20'(dt);
        return s;
    endfunction

    function automatic int any_angle();
        return int'($urandom_range(0, 2 * ANG_MAX)) - ANG_MAX;
    endfunction

    function automatic longint near_offset(int span);
        return longint'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic sample_t random_sample();
        sample_t s;
        int pick, dt;
        pick = $urandom_range(0, 99);
        case ($urandom_range(0, 3))
            0: dt = 0;
            1: dt = $urandom_range(1, 65536);
            2: dt = $urandom_range(0, 655360);
            default: dt = $urandom_range(1, 6554);
        endcase
        if (pick < 5) begin
            s = make_sample(OP_CLEAR, $urandom, $urandom, $urandom, any_angle(), any_angle(),
                            any_angle(), $urandom, $urandom, dt);
        end else if (pick < 30) begin
            s = make_sample(OP_UPDATE, signed'($urandom), signed'($urandom), signed'($urandom),
                            any_angle(), any_angle(), any_angle(), signed'($urandom),
                            signed'($urandom), dt);
        end else if (pick < 45) begin
            s = make_sample(OP_UPDATE, goal_x_q + near_offset(150000),
                            goal_y_q + near_offset(150000), goal_z_q + near_offset(150000),
                            any_angle(), any_angle(), any_angle(), near_offset(300000),
                            near_offset(300000), dt);
        end else begin
            s = make_sample(OP_UPDATE, goal_x_q + near_offset(1 << 21),
                            goal_y_q + near_offset(1 << 21), goal_z_q + near_offset(1 << 20),
                            int'(near_offset(40000)), int'(near_offset(40000)), any_angle(),
                            near_offset(1 << 18), near_offset(1 << 18), dt);
        end
        return s;
    endfunction

    task automatic test_field_extremes();
        send_request(make_sample(OP_UPDATE, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_sample(OP_UPDATE, WORD_HI, WORD_LO, WORD_HI, ANG_MAX, -ANG_MAX,
                                 ANG_MAX, WORD_HI, WORD_LO, 655360));
        send_request(make_sample(OP_UPDATE, WORD_LO, WORD_HI, WORD_LO, -ANG_MAX, ANG_MAX,
                                 -ANG_MAX, WORD_LO, WORD_HI, 1));
        send_request(make_sample(OP_UPDATE, -1, -1, -1, -1, -1, -1, -1, -1, 20'hfffff & 655360));
        send_request(make_sample(OP_UPDATE, 1000000, -2000000, 500000, 102944, -102944,
                                 154000, 65536, -65536, 524287));
        send_request(make_sample(OP_UPDATE, 0, 0, 3000000, 0, 0, 0, 0, 0, 0));
    endtask

    task automatic test_clear_memory();
        send_request(make_sample(OP_UPDATE, 0, 0, -5000000, 1000, 2000, 3000, 0, 0, 65536));
        send_request(make_sample(OP_UPDATE, 0, 0, -5000000, 1000, 2000, 3000, 0, 0, 65536));
        send_request(make_sample(OP_CLEAR, WORD_HI, WORD_LO, -1, -1, ANG_MAX, 0, WORD_HI,
                                 WORD_LO, 655360));
        send_request(make_sample(OP_UPDATE, 0, 0, -5000000, 1000, 2000, 3000, 0, 0, 65536));
        send_request(make_sample(OP_UPDATE, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    endtask

    task automatic test_goal_reached();
        write_goal(wpc_pkg::REG_GOAL_X, 655360);
        write_goal(wpc_pkg::REG_GOAL_Y, -655360);
        write_goal(wpc_pkg::REG_GOAL_Z, 327680);
        write_goal(wpc_pkg::REG_GOAL_HEADING, 51472);
        send_request(make_sample(OP_UPDATE, 655360 + 131072, -655360, 327680, 0, 0, 0, 0, 0,
                                 6554));
        send_request(make_sample(OP_UPDATE, 655360 + 92000, -655360 + 92000, 327680, 0, 0, 0,
                                 0, 0, 6554));
        send_request(make_sample(OP_UPDATE, 655360 + 65536, -655360 - 65536, 327680 + 65536,
                                 0, 0, 0, 0, 0, 6554));
        send_request(make_sample(OP_UPDATE, 0, 0, 0, 0, 0, 0, 0, 0, 6554));
        write_goal(wpc_pkg::REG_GOAL_HEADING, -51472);
        send_request(make_sample(OP_UPDATE, 655360, -655360, 327680, 0, 0, 0, 0, 0, 6554));
        send_request(make_sample(OP_UPDATE, 0, 0, 0, 0, 0, 0, 0, 0, 6554));
    endtask

    task automatic run_random(input int count);
        for (int n = 0; n < count; n++) begin
            if (n == count / 2) begin
                s_valid <= 1'b0;
                while (pending_cmds.size() != 0) @(posedge aclk);
            end
            calm = (n % 100) >= 85;
            send_request(random_sample());
        end
        calm = 1'b0;
    endtask

    task automatic test_goal_settings();
        run_random(200);
        write_goal(wpc_pkg::REG_GOAL_X, WORD_HI);
        write_goal(wpc_pkg::REG_GOAL_Y, WORD_LO);
        write_goal(wpc_pkg::REG_GOAL_Z, WORD_HI);
        write_goal(wpc_pkg::REG_GOAL_HEADING, ANG_MAX);
        run_random(200);
        write_goal(wpc_pkg::REG_GOAL_X, WORD_LO);
        write_goal(wpc_pkg::REG_GOAL_Y, WORD_HI);
        write_goal(wpc_pkg::REG_GOAL_Z, WORD_LO);
        write_goal(wpc_pkg::REG_GOAL_HEADING, -ANG_MAX);
        run_random(200);
        write_goal(wpc_pkg::REG_GOAL_X, near_offset(1 << 24));
        write_goal(wpc_pkg::REG_GOAL_Y, near_offset(1 << 24));
        write_goal(wpc_pkg::REG_GOAL_Z, near_offset(1 << 22));
        write_goal(wpc_pkg::REG_GOAL_HEADING, any_angle());
        run_random(220);
    endtask

    initial begin
        goal_x_q = 0;
        goal_y_q = 0;
        goal_z_q = 0;
        goal_hdg_q = 0;
        alt_integ = 0;
        alt_last_err = 0;
        reached_q = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_field_extremes();
        test_clear_memory();
        test_goal_reached();
        test_goal_settings();
        drain_and_settle();
        $display("covered %0d control updates and %0d pid clears, %0d commands checked",
                 requests_sent, clears_sent, commands_seen);
        $display("goal registers swept through zero, both range limits and random values");
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
